// ===== hw/rtl/sot_pkg.sv =====
package sot_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int COORD_FRAC_BITS = 8;
    localparam int SHIFT_WIDTH     = 8;
    localparam int TOL_WIDTH       = 16;
    localparam int CFG_IDX_WIDTH   = 2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_SHIFT_X = 2'd0,
        CFG_SHIFT_Y = 2'd1,
        CFG_SHIFT_Z = 2'd2,
        CFG_SQ_TOL  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_start_x;
        logic signed [COORD_WIDTH-1:0] first_start_y;
        logic signed [COORD_WIDTH-1:0] first_start_z;
        logic signed [COORD_WIDTH-1:0] first_end_x;
        logic signed [COORD_WIDTH-1:0] first_end_y;
        logic signed [COORD_WIDTH-1:0] first_end_z;
        logic signed [COORD_WIDTH-1:0] second_start_x;
        logic signed [COORD_WIDTH-1:0] second_start_y;
        logic signed [COORD_WIDTH-1:0] second_start_z;
        logic signed [COORD_WIDTH-1:0] second_end_x;
        logic signed [COORD_WIDTH-1:0] second_end_y;
        logic signed [COORD_WIDTH-1:0] second_end_z;
    } t_in_word;

    typedef struct packed {
        logic overlap;
        logic first_start_on_second;
        logic second_end_on_first;
        logic first_end_on_second;
        logic second_start_on_first;
    } t_out_word;

endpackage

// ===== hw/rtl/segment_overlap_test.sv =====
// An input word accepted into the input stage is presented as an output word once it
// has passed through every later stage in order.
// Throughput: one word per cycle while i_stall is low; the seven register stages (input,
// differences, products, dot sums, partial squares, square assembly, final compare)
// each hold one word, and a stage advances when it is empty or the next one advances.
// Reset (synchronous, active low) clears all stage valid bits and sets the
// shifts to 0 and the squared tolerance to 1.
module segment_overlap_test
    import sot_pkg::*;
#(
    parameter int FRAC_BITS = COORD_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_word                 i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out_word                o_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [TOL_WIDTH-1:0]     i_cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int BW   = ((CW > SHIFT_WIDTH + FRAC_BITS) ? CW : SHIFT_WIDTH + FRAC_BITS) + 1;
    localparam int DW   = BW + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 2;
    localparam int CXW  = PW + 1;
    localparam int MW   = PW;
    localparam int HW   = (MW + 1) / 2;
    localparam int LW   = MW - HW;
    localparam int SQW  = 2 * MW;
    localparam int CSW  = SQW + 2;
    localparam int DHW  = (SW + 1) / 2;
    localparam int DLW  = SW - DHW;
    localparam int TW   = TOL_WIDTH + SW;
    localparam int NST  = 7;

    logic signed [SHIFT_WIDTH-1:0] r_shift_x, r_shift_y, r_shift_z;
    logic [TOL_WIDTH-1:0]          r_tol;

    logic [NST-1:0] r_vld;
    logic [NST:0]   en;

    logic signed [BW-1:0] off [3];
    logic signed [BW-1:0] n_a1 [3], n_a2 [3], n_b1 [3], n_b2 [3];
    logic signed [BW-1:0] r_a1 [3], r_a2 [3], r_b1 [3], r_b2 [3];

    logic signed [BW-1:0] lp [4][3], ls [4][3], le [4][3];

    logic signed [DW-1:0]  r_d [4][3], r_f [4][3];
    logic signed [PW-1:0]  r_pq [4][3], r_pf [4][3], r_pd [4][3];
    logic signed [PW-1:0]  r_pxa [4][3], r_pxb [4][3];
    logic signed [SW-1:0]  r_q [4];
    logic [SW-1:0]         r_ff [4], r_dd [4];
    logic signed [CXW-1:0] r_c [4][3];

    logic [MW-1:0]         m [4][3];
    logic [2*LW-1:0]       r_mh2 [4][3];
    logic [LW+HW-1:0]      r_mhl [4][3];
    logic [2*HW-1:0]       r_ml2 [4][3];
    logic [TOL_WIDTH+DHW-1:0] r_tl [4];
    logic [TOL_WIDTH+DLW-1:0] r_th [4];
    logic                  r_pass5 [4], r_fail5 [4];

    logic [SQW-1:0]        r_sq [4][3];
    logic [TW-1:0]         r_tdd [4];
    logic                  r_pass6 [4], r_fail6 [4];

    logic [CSW-1:0]        csq [4];
    logic                  n_on [4];
    t_out_word             n_out, r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
            r_tol     <= TOL_WIDTH'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SHIFT_X: r_shift_x <= i_cfg_data[SHIFT_WIDTH-1:0];
                CFG_SHIFT_Y: r_shift_y <= i_cfg_data[SHIFT_WIDTH-1:0];
                CFG_SHIFT_Z: r_shift_z <= i_cfg_data[SHIFT_WIDTH-1:0];
                CFG_SQ_TOL:  r_tol     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Each stage advances when it is empty or the next one advances.
    always_comb begin
        en[NST] = !i_stall;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NST-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        off[0] = BW'(r_shift_x) <<< FRAC_BITS;
        off[1] = BW'(r_shift_y) <<< FRAC_BITS;
        off[2] = BW'(r_shift_z) <<< FRAC_BITS;
        n_a1[0] = BW'(i_data.first_start_x);
        n_a1[1] = BW'(i_data.first_start_y);
        n_a1[2] = BW'(i_data.first_start_z);
        n_a2[0] = BW'(i_data.first_end_x);
        n_a2[1] = BW'(i_data.first_end_y);
        n_a2[2] = BW'(i_data.first_end_z);
        n_b1[0] = BW'(i_data.second_start_x) + off[0];
        n_b1[1] = BW'(i_data.second_start_y) + off[1];
        n_b1[2] = BW'(i_data.second_start_z) + off[2];
        n_b2[0] = BW'(i_data.second_end_x) + off[0];
        n_b2[1] = BW'(i_data.second_end_y) + off[1];
        n_b2[2] = BW'(i_data.second_end_z) + off[2];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= n_a1[k];
                r_a2[k] <= n_a2[k];
                r_b1[k] <= n_b1[k];
                r_b2[k] <= n_b2[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lp[0][k] = r_a1[k]; ls[0][k] = r_b1[k]; le[0][k] = r_b2[k];
            lp[1][k] = r_b2[k]; ls[1][k] = r_a1[k]; le[1][k] = r_a2[k];
            lp[2][k] = r_a2[k]; ls[2][k] = r_b1[k]; le[2][k] = r_b2[k];
            lp[3][k] = r_b1[k]; ls[3][k] = r_a1[k]; le[3][k] = r_a2[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int l = 0; l < 4; l++) begin
                for (int k = 0; k < 3; k++) begin
                    r_d[l][k] <= DW'(le[l][k]) - DW'(ls[l][k]);
                    r_f[l][k] <= DW'(lp[l][k]) - DW'(ls[l][k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int l = 0; l < 4; l++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pq[l][k] <= r_d[l][k] * r_f[l][k];
                    r_pf[l][k] <= r_f[l][k] * r_f[l][k];
                    r_pd[l][k] <= r_d[l][k] * r_d[l][k];
                end
                r_pxa[l][0] <= r_d[l][1] * r_f[l][2];
                r_pxb[l][0] <= r_d[l][2] * r_f[l][1];
                r_pxa[l][1] <= r_d[l][2] * r_f[l][0];
                r_pxb[l][1] <= r_d[l][0] * r_f[l][2];
                r_pxa[l][2] <= r_d[l][0] * r_f[l][1];
                r_pxb[l][2] <= r_d[l][1] * r_f[l][0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int l = 0; l < 4; l++) begin
                r_q[l]  <= SW'(r_pq[l][0]) + SW'(r_pq[l][1]) + SW'(r_pq[l][2]);
                r_ff[l] <= SW'(r_pf[l][0]) + SW'(r_pf[l][1]) + SW'(r_pf[l][2]);
                r_dd[l] <= SW'(r_pd[l][0]) + SW'(r_pd[l][1]) + SW'(r_pd[l][2]);
                for (int k = 0; k < 3; k++) begin
                    r_c[l][k] <= CXW'(r_pxa[l][k]) - CXW'(r_pxb[l][k]);
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            for (int k = 0; k < 3; k++) begin
                m[l][k] = r_c[l][k][CXW-1] ? MW'(-r_c[l][k]) : MW'(r_c[l][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int l = 0; l < 4; l++) begin
                for (int k = 0; k < 3; k++) begin
                    r_mh2[l][k] <= m[l][k][MW-1:HW] * m[l][k][MW-1:HW];
                    r_mhl[l][k] <= m[l][k][MW-1:HW] * m[l][k][HW-1:0];
                    r_ml2[l][k] <= m[l][k][HW-1:0] * m[l][k][HW-1:0];
                end
                r_tl[l] <= r_tol * r_dd[l][DHW-1:0];
                r_th[l] <= r_tol * r_dd[l][SW-1:DHW];
                r_pass5[l] <= !r_q[l][SW-1] && (r_ff[l] < SW'(r_tol));
                r_fail5[l] <= r_q[l][SW-1] || (!(r_ff[l] < SW'(r_tol)) &&
                              ((r_dd[l] == '0) || (SW'(r_q[l]) > r_dd[l])));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int l = 0; l < 4; l++) begin
                for (int k = 0; k < 3; k++) begin
                    r_sq[l][k] <= (SQW'(r_mh2[l][k]) << (2 * HW))
                                + (SQW'(r_mhl[l][k]) << (HW + 1))
                                + SQW'(r_ml2[l][k]);
                end
                r_tdd[l]   <= (TW'(r_th[l]) << DHW) + TW'(r_tl[l]);
                r_pass6[l] <= r_pass5[l];
                r_fail6[l] <= r_fail5[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            csq[l]  = CSW'(r_sq[l][0]) + CSW'(r_sq[l][1]) + CSW'(r_sq[l][2]);
            n_on[l] = r_pass6[l] || (!r_fail6[l] && (csq[l] <= CSW'(r_tdd[l])));
        end
        n_out.first_start_on_second = n_on[0];
        n_out.second_end_on_first   = n_on[1];
        n_out.first_end_on_second   = n_on[2];
        n_out.second_start_on_first = n_on[3];
        n_out.overlap               = (n_on[0] || n_on[1]) && (n_on[2] || n_on[3]);
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_out <= n_out;
        end
    end

endmodule
